// File: rtl/core/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache engine: operation codes,
// sequencer states, ARP header values and controller/datapath buses.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned TMR_W = 8;
  localparam int unsigned IDX_W = 3;

  localparam logic [15:0]      HW_TYPE_ETH    = 16'h0001;
  localparam logic [15:0]      PROTO_IPV4     = 16'h0800;
  localparam logic [7:0]       HW_LEN_ETH     = 8'h06;
  localparam logic [7:0]       PROTO_LEN_IPV4 = 8'h04;
  localparam logic [15:0]      ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0]      ARP_OP_REPLY   = 16'd2;
  localparam logic [MAC_W-1:0] BROADCAST_MAC  = 48'hFFFF_FFFF_FFFF;
  localparam logic [TMR_W-1:0] LIFETIME_RST   = 8'hFF;

  // Configuration register indexes (paddr[4:3])
  localparam logic [1:0] REG_OWN_IP   = 2'd0;
  localparam logic [1:0] REG_OWN_MAC  = 2'd1;
  localparam logic [1:0] REG_LIFETIME = 2'd2;

  typedef enum logic [1:0] {
    OP_RESOLVE = 2'd0,
    OP_LEARN   = 2'd1,
    OP_TICK    = 2'd2,
    OP_ARP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_ACT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;     // capture request, restart search
    logic scan_rd;  // read entry at scan pointer, advance
    logic act;      // write learned entry, read matched MAC
    logic emit;     // load result register
  } cmd_t;

  typedef struct packed {
    logic scan_last;  // scan pointer at last entry
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

// File: rtl/core/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer of the ARP cache engine: accepts one request, steps the table
// scan, triggers the update and hands the result to the output register.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  arpc_pkg::sts_t sts_i,
  output arpc_pkg::cmd_t cmd_o
);
  import arpc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_LAST;
      end
      ST_LAST: state_d = ST_ACT;
      ST_ACT:  state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.load  = in_valid_i;
      end
      ST_SCAN: cmd_o.scan_rd = 1'b1;
      ST_LAST: ;
      ST_ACT:  cmd_o.act = 1'b1;
      ST_DONE: cmd_o.emit = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/arpc_dpath.sv
// ----------------------------------------------------------------------------
// arpc_dpath
// Datapath of the ARP cache engine: request registers, entry memories with
// valid bits, pipelined compare stage, update logic and result register.
// ----------------------------------------------------------------------------
module arpc_dpath #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  arpc_pkg::cmd_t              cmd_i,
  output arpc_pkg::sts_t              sts_o,
  input  logic [1:0]                  operation_i,
  input  logic [arpc_pkg::IP_W-1:0]   ip_addr_i,
  input  logic [arpc_pkg::MAC_W-1:0]  mac_addr_i,
  input  logic [arpc_pkg::IP_W-1:0]   target_ip_i,
  input  logic [15:0]                 arp_opcode_i,
  input  logic [15:0]                 hw_type_i,
  input  logic [15:0]                 proto_type_i,
  input  logic [7:0]                  hw_len_i,
  input  logic [7:0]                  proto_len_i,
  input  logic [arpc_pkg::IP_W-1:0]   own_ip_i,
  input  logic [arpc_pkg::MAC_W-1:0]  own_mac_i,
  input  logic [arpc_pkg::TMR_W-1:0]  lifetime_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic                        hit_o,
  output logic [arpc_pkg::IDX_W-1:0]  entry_index_o,
  output logic [arpc_pkg::MAC_W-1:0]  dest_mac_o,
  output logic [arpc_pkg::MAC_W-1:0]  source_mac_o,
  output logic                        learned_o,
  output logic                        dropped_full_o,
  output logic                        send_reply_o
);
  import arpc_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_ENTRIES - 1);

  // entry memories
  logic [IP_W-1:0]  ip_mem  [TABLE_ENTRIES];
  logic [MAC_W-1:0] mac_mem [TABLE_ENTRIES];
  logic [TMR_W-1:0] tmr_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_q;

  // request
  op_e              op_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic             pkt_ok_q, is_req_q;
  logic             pkt_ok, learn_en, arp_req;

  // scan and compare stage
  logic [CW-1:0]    scan_q;
  logic             cmp_vld_q, cmp_live_q;
  logic [IW-1:0]    cmp_idx_q;
  logic [IP_W-1:0]  ip_rd_q;
  logic [TMR_W-1:0] tmr_rd_q;
  logic [IP_W-1:0]  ent_ip;
  logic [TMR_W-1:0] ent_tmr;

  // search results
  logic             found_q, free_q;
  logic [IW-1:0]    found_idx_q, free_idx_q;
  logic [MAC_W-1:0] mac_rd_q;
  logic [IW-1:0]    tgt_idx;
  logic             tgt_ok;

  // timer write port
  logic             tmr_we;
  logic [IW-1:0]    tmr_wa;
  logic [TMR_W-1:0] tmr_wd;
  logic             ent_we;

  // result register
  logic             out_valid_q;
  logic             res_hit, res_learned, res_dropped, res_reply;
  logic [IDX_W-1:0] res_idx;
  logic [MAC_W-1:0] res_dest;

  assign pkt_ok = (hw_type_i == HW_TYPE_ETH) && (proto_type_i == PROTO_IPV4) &&
                  (hw_len_i == HW_LEN_ETH) && (proto_len_i == PROTO_LEN_IPV4) &&
                  (target_ip_i == own_ip_i) &&
                  ((arp_opcode_i == ARP_OP_REQUEST) || (arp_opcode_i == ARP_OP_REPLY));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_e'(operation_i);
      ip_q     <= ip_addr_i;
      mac_q    <= mac_addr_i;
      pkt_ok_q <= pkt_ok;
      is_req_q <= (arp_opcode_i == ARP_OP_REQUEST);
    end
  end

  assign learn_en = (op_q == OP_LEARN) || ((op_q == OP_ARP) && pkt_ok_q);
  assign arp_req  = (op_q == OP_ARP) && pkt_ok_q && is_req_q;

  // scan pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        scan_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_q <= scan_q + 1'b1;
      end
      cmp_vld_q <= cmd_i.scan_rd;
    end
  end

  assign sts_o.scan_last = (scan_q == LAST_IDX);

  // registered reads, one entry per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      ip_rd_q    <= ip_mem[scan_q[IW-1:0]];
      tmr_rd_q   <= tmr_mem[scan_q[IW-1:0]];
      cmp_live_q <= vld_q[scan_q[IW-1:0]];
      cmp_idx_q  <= scan_q[IW-1:0];
    end
    if (cmd_i.act) begin
      mac_rd_q <= mac_mem[found_idx_q];
    end
  end

  // entries never written read as zero IP and expired timer
  assign ent_ip  = cmp_live_q ? ip_rd_q  : '0;
  assign ent_tmr = cmp_live_q ? tmr_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      found_idx_q <= '0;
      free_idx_q  <= '0;
    end else if (cmd_i.load) begin
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      found_idx_q <= '0;
      free_idx_q  <= '0;
    end else if (cmp_vld_q) begin
      if (!found_q && (ent_ip == ip_q)) begin
        found_q     <= 1'b1;
        found_idx_q <= cmp_idx_q;
      end
      if (!free_q && (ent_tmr == '0)) begin
        free_q     <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end
    end
  end

  assign tgt_ok  = found_q || free_q;
  assign tgt_idx = found_q ? found_idx_q : free_idx_q;
  assign ent_we  = cmd_i.act && learn_en && tgt_ok;

  // timer port: age during a tick scan, reload on learn
  always_comb begin
    tmr_we = 1'b0;
    tmr_wa = cmp_idx_q;
    tmr_wd = ent_tmr - 1'b1;
    if (ent_we) begin
      tmr_we = 1'b1;
      tmr_wa = tgt_idx;
      tmr_wd = lifetime_i;
    end else if (cmp_vld_q && (op_q == OP_TICK) && (ent_tmr != '0)) begin
      tmr_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tmr_we) begin
      tmr_mem[tmr_wa] <= tmr_wd;
    end
    if (ent_we) begin
      ip_mem[tgt_idx]  <= ip_q;
      mac_mem[tgt_idx] <= mac_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ent_we) begin
      vld_q[tgt_idx] <= 1'b1;
    end
  end

  // result
  always_comb begin
    res_hit     = 1'b0;
    res_idx     = '0;
    res_dest    = '0;
    res_learned = 1'b0;
    res_dropped = 1'b0;
    res_reply   = 1'b0;
    if (op_q == OP_RESOLVE) begin
      res_hit  = found_q;
      res_idx  = found_q ? IDX_W'(found_idx_q) : '0;
      res_dest = found_q ? mac_rd_q : BROADCAST_MAC;
    end else if (learn_en) begin
      res_hit     = found_q;
      res_idx     = tgt_ok ? IDX_W'(tgt_idx) : '0;
      res_learned = tgt_ok;
      res_dropped = !tgt_ok;
      res_reply   = arp_req;
      res_dest    = arp_req ? mac_q : '0;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      hit_o          <= res_hit;
      entry_index_o  <= res_idx;
      dest_mac_o     <= res_dest;
      source_mac_o   <= own_mac_i;
      learned_o      <= res_learned;
      dropped_full_o <= res_dropped;
      send_reply_o   <= res_reply;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/arp_cache_engine.sv
// ----------------------------------------------------------------------------
// arp_cache_engine
// ARP cache of IPv4-to-MAC entries with lifetime aging: resolve, learn,
// tick and ARP packet handling over a scanned entry table.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake             | Payload
//   ---------+-----------+-----------------------+-------------------------------
//   request  | in        | in_valid_i/in_stall_o | operation, ip/mac, ARP header
//   result   | out       | out_valid_o/out_stall_i | hit, index, MACs, flags
//   config   | in/out    | APB psel/penable      | own_ip, own_mac, entry_lifetime
//
// A request passes through one accept step, one read per entry through the
// single read port of the entry memories, a compare drain step, an
// update/MAC-read step and a result-register load step. The next request
// is taken in the cycle after the result is loaded. Reset
// clears all valid bits at once: the table reads as zero IPs with expired
// timers, no clearing pass. A stalled result holds in the output register;
// the sequencer waits in its final state until the register frees.
// Registers sit at byte address 8*i (64-bit data): own_ip, own_mac, lifetime.
// ----------------------------------------------------------------------------
module arp_cache_engine #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic [arpc_pkg::IP_W-1:0]   ip_addr_i,
  input  logic [arpc_pkg::MAC_W-1:0]  mac_addr_i,
  input  logic [arpc_pkg::IP_W-1:0]   target_ip_i,
  input  logic [15:0]                 arp_opcode_i,
  input  logic [15:0]                 hw_type_i,
  input  logic [15:0]                 proto_type_i,
  input  logic [7:0]                  hw_len_i,
  input  logic [7:0]                  proto_len_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic [arpc_pkg::IDX_W-1:0]  entry_index_o,
  output logic [arpc_pkg::MAC_W-1:0]  dest_mac_o,
  output logic [arpc_pkg::MAC_W-1:0]  source_mac_o,
  output logic                        learned_o,
  output logic                        dropped_full_o,
  output logic                        send_reply_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import arpc_pkg::*;

  logic [IP_W-1:0]  own_ip_q;
  logic [MAC_W-1:0] own_mac_q;
  logic [TMR_W-1:0] lifetime_q;
  logic             cfg_we;
  logic [1:0]       reg_sel;
  cmd_t             cmd;
  sts_t             sts;

  // Configuration registers: write on the access phase, no wait states.
  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q   <= '0;
      own_mac_q  <= '0;
      lifetime_q <= LIFETIME_RST;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_OWN_IP:   own_ip_q   <= pwdata[IP_W-1:0];
        REG_OWN_MAC:  own_mac_q  <= pwdata[MAC_W-1:0];
        REG_LIFETIME: lifetime_q <= pwdata[TMR_W-1:0];
        default: ;  // unmapped address: drop
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_OWN_IP:   prdata = 64'(own_ip_q);
      REG_OWN_MAC:  prdata = 64'(own_mac_q);
      REG_LIFETIME: prdata = 64'(lifetime_q);
      default:      prdata = '0;
    endcase
  end

  // Sequencer: accept, scan, update, hand off the result.
  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Entry table, search and result register.
  arpc_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .ip_addr_i      (ip_addr_i),
    .mac_addr_i     (mac_addr_i),
    .target_ip_i    (target_ip_i),
    .arp_opcode_i   (arp_opcode_i),
    .hw_type_i      (hw_type_i),
    .proto_type_i   (proto_type_i),
    .hw_len_i       (hw_len_i),
    .proto_len_i    (proto_len_i),
    .own_ip_i       (own_ip_q),
    .own_mac_i      (own_mac_q),
    .lifetime_i     (lifetime_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .hit_o          (hit_o),
    .entry_index_o  (entry_index_o),
    .dest_mac_o     (dest_mac_o),
    .source_mac_o   (source_mac_o),
    .learned_o      (learned_o),
    .dropped_full_o (dropped_full_o),
    .send_reply_o   (send_reply_o)
  );

endmodule
